@@ design/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg: shared types for the positional list engine
// Request and status codes, cell commands and sequencer states.
// ----------------------------------------------------------------------------
package ple_pkg;

   // list capacity; the index and count fields are sized for it
   localparam int DEPTH    = 16;

   localparam int DATA_W   = 32;
   localparam int POS_W    = 5;
   localparam int INDEX_W  = 4;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;
   localparam int REQ_W    = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_PUSH_HEAD = 2'd0,
      REQ_PUSH_TAIL = 2'd1,
      REQ_DELETE    = 2'd2,
      REQ_READ      = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_BOUNDS = 2'd2,
      STAT_FULL   = 2'd3
   } status_type;

   // what every cell in the row does this cycle
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_HEAD,
      CELL_PUSH_TAIL,
      CELL_DELETE,
      CELL_ROTATE
   } cell_cmd_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_READ
   } fsm_type;

endpackage

@@ design/ple_cell.sv @@
// ----------------------------------------------------------------------------
// ple_cell: one list slot
// Holds one entry; takes a neighbor's value when the row shifts, the request
// value on a tail push into it, or the head entry when it wraps on rotate.
module ple_cell #(
   parameter int IDX = 0,
   parameter int CW  = 5
) (
   input  logic                              clock,
   input  ple_pkg::cell_cmd_type             cmd,
   input  logic [CW-1:0]                     cnt,
   input  logic [CW-1:0]                     del_from,
   input  logic signed [ple_pkg::DATA_W-1:0] in_value,
   input  logic signed [ple_pkg::DATA_W-1:0] prev_data,
   input  logic signed [ple_pkg::DATA_W-1:0] next_data,
   input  logic signed [ple_pkg::DATA_W-1:0] head_data,
   output logic signed [ple_pkg::DATA_W-1:0] data
);
   import ple_pkg::*;

   localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
   localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   // slot update for the current command
   always_comb begin
      data_in = data_ff;
      case (cmd)
         CELL_PUSH_HEAD: data_in = prev_data;
         CELL_PUSH_TAIL: begin
            if (MY_IDX == cnt) data_in = in_value;
         end
         CELL_DELETE: begin
            if (MY_IDX >= del_from) data_in = next_data;
         end
         CELL_ROTATE: begin
            // rotate only the occupied part; the head entry wraps into the last occupied slot
            if (MY_NEXT == cnt) data_in = head_data;
            else if (MY_NEXT < cnt) data_in = next_data;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

@@ design/positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of signed 32-bit values
// A row of DEPTH cells holds the entries in order; inserts and deletes shift
// the row in one cycle, read out rotates it past cell 0 one entry a cycle.
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------
//   req     | in        | req_valid, req_stall, req_type/value/position
//   rsp     | out       | rsp_valid, rsp_stall, rsp_status/value_res/index/count/last
//
// Inserts, deletes and failed requests: one cycle, one result.
// Read out of n entries: n+1 cycles, one result per cycle after the transfer;
// the rotation through cell 0 sets that pace. A new request is taken once
// the last result is loaded in the output register.
// Reset clears the entry count and the sequencer; cell contents are not reset.
// A stalled result holds in the output register and stops the read rotation.
// ----------------------------------------------------------------------------
module positional_list_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ple_pkg::REQ_W-1:0]           req_type,
   input  logic signed [ple_pkg::DATA_W-1:0]   req_value,
   input  logic [ple_pkg::POS_W-1:0]           req_position,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ple_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [ple_pkg::DATA_W-1:0]   rsp_value_res,
   output logic [ple_pkg::INDEX_W-1:0]         rsp_index,
   output logic [ple_pkg::COUNT_W-1:0]         rsp_count,
   output logic                                rsp_last
);
   import ple_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
   localparam logic [CW-1:0] ONE      = CW'(1);

   fsm_type                  state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            rd_idx_ff, rd_idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [INDEX_W-1:0]       rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     out_free, accept, rsp_load;
   logic                     is_full, is_empty, pos_bad, read_last;
   logic [CW-1:0]            del_from;
   cell_cmd_type             cell_cmd;
   logic signed [DATA_W-1:0] cell_q [DEPTH];
   req_code_type             req_code;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != FSM_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign req_code  = req_code_type'(req_type);

   // request checks
   assign is_full   = (count_ff == FULL_CNT);
   assign is_empty  = (count_ff == '0);
   assign pos_bad   = (req_position == '0) ||
                      ({27'd0, req_position} > 32'(count_ff));
   assign del_from  = CW'(req_position - 5'd1);
   assign read_last = ((rd_idx_ff + ONE) == count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept && req_code == REQ_READ && !is_empty) state_in = FSM_READ;
         end
         FSM_READ: begin
            if (out_free && read_last) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // outputs: cell command, count update, result load
   always_comb begin
      cell_cmd      = CELL_HOLD;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_load      = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_value_in  = '0;
      rsp_index_in  = '0;
      rsp_last_in   = 1'b1;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               rsp_load = 1'b1;
               case (req_code)
                  REQ_PUSH_HEAD, REQ_PUSH_TAIL: begin
                     if (is_full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        cell_cmd = (req_code == REQ_PUSH_HEAD) ? CELL_PUSH_HEAD
                                                               : CELL_PUSH_TAIL;
                        count_in = count_ff + ONE;
                     end
                  end
                  REQ_DELETE: begin
                     if (is_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else if (pos_bad) begin
                        rsp_status_in = STAT_BOUNDS;
                     end else begin
                        cell_cmd = CELL_DELETE;
                        count_in = count_ff - ONE;
                     end
                  end
                  REQ_READ: begin
                     rd_idx_in = '0;
                     if (is_empty) rsp_status_in = STAT_EMPTY;
                     else rsp_load = 1'b0;
                  end
                  default: rsp_load = 1'b1;
               endcase
            end
         end
         FSM_READ: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               cell_cmd     = CELL_ROTATE;
               rsp_value_in = cell_q[0];
               rsp_index_in = INDEX_W'(rd_idx_ff);
               rsp_last_in  = read_last;
               rd_idx_in    = rd_idx_ff + ONE;
            end
         end
         default: cell_cmd = CELL_HOLD;
      endcase
      rsp_count_in = COUNT_W'(count_in);
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_index     = rsp_index_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_last      = rsp_last_ff;

   // row of cells, neighbors wired both ways
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] prev_d, next_d;
      if (i == 0) begin : g_first
         assign prev_d = req_value;
      end else begin : g_mid
         assign prev_d = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_end
         assign next_d = cell_q[i];
      end else begin : g_inner
         assign next_d = cell_q[i+1];
      end
      ple_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock     (clock),
         .cmd       (cell_cmd),
         .cnt       (count_ff),
         .del_from  (del_from),
         .in_value  (req_value),
         .prev_data (prev_d),
         .next_data (next_d),
         .head_data (cell_q[0]),
         .data      (cell_q[i])
      );
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above depth");

   a_read_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_READ) |-> (rd_idx_ff < count_ff))
      else $error("read index past entry count");

   a_count_quiet: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("entry count changed without a request transfer");

   a_nonlast_in_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff == FSM_READ))
      else $error("non-final result outside read out");

   a_nonlast_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_status_ff == STAT_OK))
      else $error("non-final result with error status");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the positional list engine
// A table of directed requests covers empty, bounds, full, head, tail and
// middle deletes, then about 430 random requests follow in fill, drain and
// mixed phases. Every result is checked against the table or a list tracker in the bench.
// The sender runs in bursts and the receiver stalls on its own pattern,
// including one long hold that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ple_pkg::*;

   localparam int LIST_DEPTH   = DEPTH;
   localparam int RANDOM_ITEMS = 430;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_HOLD    = 300;

   typedef struct packed {
      status_type  status;
      logic [31:0] value;
      logic [3:0]  index;
      logic [4:0]  count;
      logic        last;
   } list_rsp_type;

   typedef struct packed {
      req_code_type kind;
      logic [31:0]  value;
      logic [4:0]   pos;
      int           reps;
      bit           typed;
      status_type   st;
      logic [4:0]   cnt;
   } step_type;

   logic                       clock;
   logic                       reset        = 1'b1;
   logic                       req_valid    = 1'b0;
   logic                       req_stall;
   logic [REQ_W-1:0]           req_type     = '0;
   logic signed [DATA_W-1:0]   req_value    = '0;
   logic [POS_W-1:0]           req_position = '0;
   logic                       rsp_valid;
   logic                       rsp_stall    = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [DATA_W-1:0]   rsp_value_res;
   logic [INDEX_W-1:0]         rsp_index;
   logic [COUNT_W-1:0]         rsp_count;
   logic                       rsp_last;

   // list tracker state and the results still owed by the block
   logic [31:0]  list_cells [LIST_DEPTH];
   int           list_len = 0;
   list_rsp_type predicted_rsp [$];
   list_rsp_type awaited_rsp [$];
   int           mismatches = 0;
   int           cycle_count = 0;
   int           burst_left = 0;

   // directed requests; typed rows carry their result, the rest use the tracker
   step_type directed_steps [19] = '{
      '{REQ_READ,      32'h0000_0000, 5'd0,  1,  1'b1, STAT_EMPTY,  5'd0},
      '{REQ_DELETE,    32'h0000_0000, 5'd0,  1,  1'b1, STAT_EMPTY,  5'd0},
      '{REQ_DELETE,    32'hFFFF_FFFF, 5'd31, 1,  1'b1, STAT_EMPTY,  5'd0},
      '{REQ_PUSH_HEAD, 32'h7FFF_FFFF, 5'd0,  1,  1'b1, STAT_OK,     5'd1},
      '{REQ_PUSH_TAIL, 32'h8000_0000, 5'd31, 1,  1'b1, STAT_OK,     5'd2},
      '{REQ_PUSH_HEAD, 32'hFFFF_FFFF, 5'd0,  1,  1'b1, STAT_OK,     5'd3},
      '{REQ_PUSH_TAIL, 32'h0000_0000, 5'd0,  1,  1'b1, STAT_OK,     5'd4},
      '{REQ_READ,      32'h0000_0000, 5'd0,  1,  1'b0, STAT_OK,     5'd0},
      '{REQ_DELETE,    32'h0000_0000, 5'd0,  1,  1'b1, STAT_BOUNDS, 5'd4},
      '{REQ_DELETE,    32'h0000_0000, 5'd5,  1,  1'b1, STAT_BOUNDS, 5'd4},
      '{REQ_PUSH_TAIL, 32'h0000_0100, 5'd0,  12, 1'b0, STAT_OK,     5'd0},
      '{REQ_PUSH_HEAD, 32'h5A5A_5A5A, 5'd0,  1,  1'b1, STAT_FULL,   5'd16},
      '{REQ_PUSH_TAIL, 32'hA5A5_A5A5, 5'd0,  1,  1'b1, STAT_FULL,   5'd16},
      '{REQ_READ,      32'h0000_0000, 5'd0,  1,  1'b0, STAT_OK,     5'd0},
      '{REQ_DELETE,    32'h0000_0000, 5'd17, 1,  1'b1, STAT_BOUNDS, 5'd16},
      '{REQ_DELETE,    32'h0000_0000, 5'd16, 1,  1'b1, STAT_OK,     5'd15},
      '{REQ_DELETE,    32'h0000_0000, 5'd1,  1,  1'b1, STAT_OK,     5'd14},
      '{REQ_DELETE,    32'h0000_0000, 5'd7,  1,  1'b1, STAT_OK,     5'd13},
      '{REQ_READ,      32'h0000_0000, 5'd0,  1,  1'b0, STAT_OK,     5'd0}
   };

   positional_list_engine dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_value_res(rsp_value_res),
      .rsp_index    (rsp_index),
      .rsp_count    (rsp_count),
      .rsp_last     (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // single-result outcome of a request, count taken after the update
   function automatic void note_single(input status_type st);
      predicted_rsp.push_back('{st, 32'h0, 4'd0, 5'(list_len), 1'b1});
   endfunction

   // apply one request to the tracked list and queue the results it causes
   function automatic void apply_to_list(input req_code_type kind,
                                         input logic [31:0] v,
                                         input logic [4:0] p);
      case (kind)
         REQ_PUSH_HEAD: begin
            if (list_len >= LIST_DEPTH) begin
               note_single(STAT_FULL);
            end else begin
               for (int i = list_len; i > 0; i--) list_cells[i] = list_cells[i-1];
               list_cells[0] = v;
               list_len++;
               note_single(STAT_OK);
            end
         end
         REQ_PUSH_TAIL: begin
            if (list_len >= LIST_DEPTH) begin
               note_single(STAT_FULL);
            end else begin
               list_cells[list_len] = v;
               list_len++;
               note_single(STAT_OK);
            end
         end
         REQ_DELETE: begin
            if (list_len == 0) begin
               note_single(STAT_EMPTY);
            end else if (p == 0 || int'(p) > list_len) begin
               note_single(STAT_BOUNDS);
            end else begin
               for (int i = int'(p) - 1; i + 1 < list_len; i++)
                  list_cells[i] = list_cells[i+1];
               list_len--;
               note_single(STAT_OK);
            end
         end
         default: begin
            if (list_len == 0) begin
               note_single(STAT_EMPTY);
            end else begin
               for (int i = 0; i < list_len; i++)
                  predicted_rsp.push_back('{STAT_OK, list_cells[i], 4'(i),
                                            5'(list_len), i + 1 == list_len});
            end
         end
      endcase
   endfunction

   // present one request, hold it until the transfer, then book its results
   task automatic offer(input req_code_type kind, input logic [31:0] v,
                        input logic [4:0] p, input bit typed,
                        input status_type st, input logic [4:0] cnt);
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_value    <= v;
      req_position <= p;
      do @(posedge clock); while (req_stall);
      predicted_rsp.delete();
      apply_to_list(kind, v, p);
      if (typed) begin
         awaited_rsp.push_back('{st, 32'h0, 4'd0, cnt, 1'b1});
      end else begin
         foreach (predicted_rsp[i]) awaited_rsp.push_back(predicted_rsp[i]);
      end
   endtask

   // sender pacing: bursts of random length, random gaps between them
   task automatic pace();
      int gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // request side: reset, directed table, random phases, drain and verdict
   initial begin : req_driver
      int           n;
      int           r;
      int           mode;
      req_code_type kind;
      logic [31:0]  v;
      logic [4:0]   p;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[s]) begin
         for (int rep = 0; rep < directed_steps[s].reps; rep++) begin
            offer(directed_steps[s].kind, directed_steps[s].value + rep,
                  directed_steps[s].pos, directed_steps[s].typed,
                  directed_steps[s].st, directed_steps[s].cnt);
            pace();
         end
      end

      // mode 0 fills, mode 1 drains, mode 2 mixes
      mode = 0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) mode = $urandom_range(0, 2);
         r = $urandom_range(0, 99);
         if (r < (mode == 0 ? 65 : mode == 1 ? 20 : 40)) begin
            kind = ($urandom_range(0, 1) == 0) ? REQ_PUSH_HEAD : REQ_PUSH_TAIL;
         end else if (r < (mode == 2 ? 80 : 85)) begin
            kind = REQ_DELETE;
         end else begin
            kind = REQ_READ;
         end

         case ($urandom_range(0, 9))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
            default: v = $urandom;
         endcase

         // mostly valid positions, with zero, one past the end and noise
         r = $urandom_range(0, 9);
         if (kind != REQ_DELETE || r == 9)
            p = 5'($urandom_range(0, 31));
         else if (r == 7)
            p = 5'd0;
         else if (r == 8)
            p = 5'(list_len + 1);
         else
            p = 5'($urandom_range(1, list_len > 0 ? list_len : 1));

         offer(kind, v, p, 1'b0, STAT_OK, 5'd0);
         pace();
      end

      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver stall pattern, one long hold so the block backs up
   initial begin : rsp_pacing
      int seg;
      int mode;
      int span;

      seg = 0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (seg == 4) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 150);
            repeat (span) begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  default: rsp_stall <= ($urandom_range(0, 3) != 0);
               endcase
               @(posedge clock);
            end
         end
         seg++;
      end
   end

   function automatic void field_check(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: rsp %s expected %0h actual %0h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // result checker: each transfer against the oldest expectation
   always @(posedge clock) begin : rsp_check
      list_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsp.size() == 0) begin
            $display("%0t: rsp transfer expected none actual status %0d value %0h",
                     $time, rsp_status, rsp_value_res);
            $display("%0t:   index %0d count %0d last %0b",
                     $time, rsp_index, rsp_count, rsp_last);
            mismatches++;
         end else begin
            want = awaited_rsp.pop_front();
            field_check("status", 32'(want.status), 32'(rsp_status));
            field_check("value_res", want.value, rsp_value_res);
            field_check("index", 32'(want.index), 32'(rsp_index));
            field_check("count", 32'(want.count), 32'(rsp_count));
            field_check("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run limit reached, %0d results outstanding",
                  $time, awaited_rsp.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
